[design/bsf_pkg.sv]
package bsf_pkg;
   localparam int MAX_ORDER_DEF   = 16;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int ORDER_BITS      = 5;
   localparam logic [ORDER_BITS-1:0] ORDER_RESET = 5'd2;

   // Control handed from the sequencer to every window cell
   typedef struct packed {
      logic shift;
      logic rotate;
      logic clear;
   } cell_ctl_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MAC    = 6'b000010,
      ST_DIV    = 6'b000100,
      ST_OUT    = 6'b001000,
      ST_ROT    = 6'b010000,
      ST_WGT    = 6'b100000
   } state_type;
endpackage

[design/bsf_cell.sv]
// One window entry: loads from its newer neighbor on shift, rotates on rotate
module bsf_cell #(
   parameter int SAMPLE_BITS = bsf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bsf_pkg::cell_ctl_type      ctl,
   input  logic                       valid_prev,
   input  logic signed [SAMPLE_BITS-1:0] data_prev,
   output logic                       valid_out,
   output logic signed [SAMPLE_BITS-1:0] data_out
);
   logic                          valid_ff;
   logic signed [SAMPLE_BITS-1:0] data_ff;

   // hold, shift or rotate the entry, or clear its valid bit
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift || ctl.rotate) begin
         valid_ff <= valid_prev;
      end
      if (ctl.shift || ctl.rotate) begin
         data_ff <= data_prev;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule

[design/bsf_divider.sv]
// Restoring divider of a magnitude by a weight total, one bit a cycle
module bsf_divider #(
   parameter int NUM_BITS = 56,
   parameter int DEN_BITS = 18
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);
   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS:0]   r_ff, r_in;
   logic [DEN_BITS-1:0] d_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic [DEN_BITS:0]   trial;

   // shift in one numerator bit and try a subtraction
   always_comb begin
      trial = {r_ff[DEN_BITS-1:0], q_ff[NUM_BITS-1]};
      q_in  = {q_ff[NUM_BITS-2:0], 1'b0};
      r_in  = trial;
      if (trial >= {1'b0, d_ff}) begin
         r_in    = trial - {1'b0, d_ff};
         q_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(NUM_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
      if (start) begin
         q_ff <= numer;
         r_ff <= '0;
         d_ff <= denom;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign quot = q_ff;
endmodule

[design/binomial_smoothing_filter.sv]
// Binomial smoothing filter.
// Input words arrive on req_ (req_valid/req_stall); each is a signed sample
// and an is_last flag. Results leave on rsp_ (rsp_valid/rsp_stall) as the
// smoothed value and is_last_res. The order register is written through
// csr_valid/csr_ready/csr_data while the block is idle; a write reloads the
// Pascal row and restarts the sequence.
// Each output is a multiply-accumulate while the window cells turn past one
// tap cell, a bit-serial divide, a load of the result register, and the rest
// of one full turn of the cells. A sample that produces no output is only
// shifted into the window and counted as pending. A last sample emits up to
// ceil(order/2)+1 outputs back to back through the same loop.
// Reset is synchronous: order returns to 2, window and counts clear.
// When the receiver stalls, the result register holds and the sequencer waits;
// the next sample is not taken until every output of the current one has left.
module binomial_smoothing_filter #(
   parameter int MAX_ORDER   = bsf_pkg::MAX_ORDER_DEF,
   parameter int SAMPLE_BITS = bsf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_smoothed,
   output logic                          rsp_is_last_res,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsf_pkg::ORDER_BITS-1:0] csr_data
);
   localparam int DEPTH  = MAX_ORDER + 1;
   localparam int OB     = bsf_pkg::ORDER_BITS;
   localparam int WB     = MAX_ORDER + 2;
   localparam int PB     = SAMPLE_BITS + WB;
   localparam int AB     = PB + 6;
   localparam int IB     = $clog2(DEPTH + 1);

   // window cells
   bsf_pkg::cell_ctl_type      ctl;
   logic                       cv [DEPTH];
   logic signed [SAMPLE_BITS-1:0] cd [DEPTH];
   logic                       head_v;
   logic signed [SAMPLE_BITS-1:0] head_d;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      bsf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .valid_prev(g == 0 ? head_v : cv[g-1]),
         .data_prev (g == 0 ? head_d : cd[g-1]),
         .valid_out(cv[g]), .data_out(cd[g])
      );
   end

   // weights, Pascal row
   logic [WB-1:0] wt_ff [DEPTH];
   logic [OB-1:0] order_ff, pend_ff, lag_ff, wrow_ff;
   logic [IB-1:0] step_ff;
   logic          last_ff, lastp_ff;
   logic          sample_in_ff;
   logic signed [SAMPLE_BITS-1:0] samp_ff;
   bsf_pkg::state_type state_ff;

   logic signed [AB-1:0] acc_ff;
   logic [WB+4:0]        tot_ff;
   logic signed [PB:0]   prod_ff;
   logic                 prod_v_ff;
   logic [WB-1:0]        wsel;
   logic                 div_start_ff, div_done, neg_ff;
   logic [AB-1:0]        div_q, mag;
   logic [OB-1:0]        half, ahead, tap;
   logic signed [OB+1:0] dpos;

   assign half  = order_ff >> 1;
   assign ahead = order_ff - half;
   assign head_v = ctl.shift ? 1'b1 : cv[DEPTH-1];
   assign head_d = ctl.shift ? samp_ff : cd[DEPTH-1];

   // Each rotation moves every entry one cell older, so after k rotations
   // entry d sits in cell d+k. Tap j uses entry d = lag + half - j, which
   // therefore always lies in cell lag + half when wrow_ff = j.
   assign tap = lag_ff + half;
   always_comb begin
      dpos = $signed({2'b00, lag_ff}) + $signed({2'b00, half})
             - $signed({2'b00, wrow_ff});
      wsel = wt_ff[wrow_ff];
   end

   logic csr_fire;
   assign csr_ready = (state_ff == bsf_pkg::ST_IDLE) && !rsp_valid && !sample_in_ff;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_stall = !(state_ff == bsf_pkg::ST_IDLE) || rsp_valid || sample_in_ff ||
                      csr_valid;
   assign mag = acc_ff[AB-1] ? AB'(-acc_ff) : AB'(acc_ff);

   // shift on a new word, turn the cells once per output, clear between sequences and on an order write
   always_comb begin
      ctl = '0;
      ctl.shift  = sample_in_ff;
      ctl.rotate = ((state_ff == bsf_pkg::ST_ROT) || (state_ff == bsf_pkg::ST_MAC)) &&
                   (step_ff != IB'(DEPTH));
      ctl.clear  = csr_fire ||
                   ((state_ff == bsf_pkg::ST_ROT) && (step_ff == IB'(DEPTH)) &&
                    last_ff && (lag_ff == '0));
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsf_pkg::ST_WGT;
         order_ff     <= bsf_pkg::ORDER_RESET;
         wrow_ff      <= '0;
         pend_ff      <= '0;
         rsp_valid    <= 1'b0;
         sample_in_ff <= 1'b0;
         div_start_ff <= 1'b0;
         prod_v_ff    <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         sample_in_ff <= 1'b0;
         prod_v_ff    <= 1'b0;
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         case (state_ff)
            bsf_pkg::ST_WGT: begin
               // build one Pascal row a cycle
               if (wrow_ff == '0) begin
                  for (int k = 0; k < DEPTH; k++) wt_ff[k] <= (k == 0) ? WB'(1) : '0;
               end else begin
                  for (int k = 1; k < DEPTH; k++) wt_ff[k] <= wt_ff[k] + wt_ff[k-1];
               end
               if (wrow_ff == order_ff) state_ff <= bsf_pkg::ST_IDLE;
               else wrow_ff <= wrow_ff + 1'b1;
            end
            bsf_pkg::ST_IDLE: begin
               if (csr_fire) begin
                  order_ff <= (csr_data > OB'(MAX_ORDER)) ? OB'(MAX_ORDER) : csr_data;
                  wrow_ff  <= '0;
                  pend_ff  <= '0;
                  state_ff <= bsf_pkg::ST_WGT;
               end else if (req_valid && !req_stall) begin
                  samp_ff      <= req_sample;
                  last_ff      <= req_is_last;
                  sample_in_ff <= 1'b1;
               end else if (sample_in_ff) begin
                  if (!last_ff && pend_ff < ahead) begin
                     pend_ff <= pend_ff + 1'b1;
                  end else begin
                     lag_ff   <= last_ff ? pend_ff : ahead;
                     lastp_ff <= last_ff && (pend_ff == '0);
                     step_ff  <= '0;
                     wrow_ff  <= '0;
                     acc_ff   <= '0;
                     tot_ff   <= '0;
                     state_ff <= bsf_pkg::ST_MAC;
                  end
               end
            end
            bsf_pkg::ST_MAC: begin
               // the tap cell holds entry lag+half-wrow_ff as the cells turn
               if (prod_v_ff) begin
                  acc_ff <= acc_ff + AB'(prod_ff);
               end
               if (step_ff != IB'(DEPTH)) begin
                  step_ff <= step_ff + 1'b1;
               end
               if (wrow_ff <= order_ff && dpos >= 0 && cv[tap]) begin
                  prod_ff   <= (PB+1)'($signed(cd[tap]) * $signed({1'b0, wsel}));
                  prod_v_ff <= 1'b1;
                  tot_ff    <= tot_ff + (WB+5)'(wsel);
               end
               if (wrow_ff <= order_ff) wrow_ff <= wrow_ff + 1'b1;
               else if (!prod_v_ff) begin
                  neg_ff       <= acc_ff[AB-1];
                  div_start_ff <= 1'b1;
                  state_ff     <= bsf_pkg::ST_DIV;
               end
            end
            bsf_pkg::ST_DIV: begin
               if (div_done) state_ff <= bsf_pkg::ST_OUT;
            end
            bsf_pkg::ST_OUT: begin
               if (!rsp_valid) begin
                  rsp_smoothed    <= neg_ff ? SAMPLE_BITS'(-div_q) : SAMPLE_BITS'(div_q);
                  rsp_is_last_res <= lastp_ff;
                  rsp_valid       <= 1'b1;
                  state_ff        <= bsf_pkg::ST_ROT;
               end
            end
            bsf_pkg::ST_ROT: begin
               // finish the full turn so every cell is back in place
               if (step_ff == IB'(DEPTH)) begin
                  if (last_ff && lag_ff != '0) begin
                     lag_ff   <= lag_ff - 1'b1;
                     lastp_ff <= (lag_ff == OB'(1));
                     step_ff  <= '0;
                     wrow_ff  <= '0;
                     acc_ff   <= '0;
                     tot_ff   <= '0;
                     state_ff <= bsf_pkg::ST_MAC;
                  end else begin
                     if (last_ff) pend_ff <= '0;
                     state_ff <= bsf_pkg::ST_IDLE;
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            default: state_ff <= bsf_pkg::ST_IDLE;
         endcase
      end
   end

   bsf_divider #(.NUM_BITS(AB), .DEN_BITS(WB+5)) u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .numer(mag), .denom(tot_ff == '0 ? (WB+5)'(1) : tot_ff),
      .done(div_done), .quot(div_q)
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_smoothed)))
      else $error("result changed under stall");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bsf_pkg::ST_IDLE) |-> req_stall) else $error("busy accept");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !rsp_valid) else $error("cfg while busy");
   a_order_max: assert property (@(posedge clock) disable iff (reset)
      order_ff <= OB'(MAX_ORDER)) else $error("order out of range");
endmodule

[bench/tb_binomial_smoothing_filter.sv]
module tb_binomial_smoothing_filter;
   localparam int MAX_ORDER   = bsf_pkg::MAX_ORDER_DEF;
   localparam int SAMPLE_BITS = bsf_pkg::SAMPLE_BITS_DEF;
   localparam int OB          = bsf_pkg::ORDER_BITS;
   localparam int SETTLE      = 200;
   localparam int WATCHDOG    = 6000;
   localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S_MIN = 32'sh80000000;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          is_last;
   } sample_word_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] smoothed;
      logic                          is_last_res;
   } smooth_word_type;

   logic clock;
   logic reset;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic req_is_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_smoothed;
   logic rsp_is_last_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [OB-1:0] csr_data = '0;

   sample_word_type sample_q[$];
   smooth_word_type smoothed_q[$];
   int  mismatches = 0;
   bit  quiet = 1'b0;

   // filter state mirror
   logic signed [SAMPLE_BITS-1:0] win[MAX_ORDER+1];
   int unsigned pascal_row[MAX_ORDER+1];
   int unsigned order, fill, owed;

   binomial_smoothing_filter u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   // load the Pascal row and restart the sequence
   task automatic set_order(input int unsigned v);
      order = (v > MAX_ORDER) ? MAX_ORDER : v;
      foreach (pascal_row[i]) pascal_row[i] = 0;
      pascal_row[0] = 1;
      for (int r = 1; r <= order; r++)
         for (int j = r; j >= 1; j--) pascal_row[j] += pascal_row[j-1];
      fill = 0;
      owed = 0;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] smooth_at(input int unsigned lag);
      longint acc;
      longint total;
      longint q;
      int d;
      acc = 0;
      total = 0;
      for (int j = 0; j <= int'(order); j++) begin
         d = int'(lag) + int'(order / 2) - j;
         if (d >= 0 && d < int'(fill)) begin
            acc += longint'(win[d]) * longint'(pascal_row[j]);
            total += pascal_row[j];
         end
      end
      if (total == 0) total = 1;
      q = acc / total;
      return q[SAMPLE_BITS-1:0];
   endfunction

   // advance the window by one word and queue what it releases
   task automatic predict_smoothed(input sample_word_type w);
      int unsigned ahead;
      smooth_word_type r;
      ahead = order - order / 2;
      for (int i = MAX_ORDER; i > 0; i--) win[i] = win[i-1];
      win[0] = w.sample;
      if (fill < order + 1) fill++;
      if (!w.is_last) begin
         if (owed < ahead) owed++;
         else begin
            r.smoothed = smooth_at(ahead);
            r.is_last_res = 1'b0;
            smoothed_q.push_back(r);
         end
      end else begin
         for (int p = int'(owed); p >= 0; p--) begin
            r.smoothed = smooth_at(p);
            r.is_last_res = (p == 0);
            smoothed_q.push_back(r);
         end
         fill = 0;
         owed = 0;
      end
   endtask

   // input driver
   int req_gap = 0;
   always @(posedge clock) begin
      sample_word_type w;
      if (req_valid && !req_stall) predict_smoothed('{req_sample, req_is_last});
      if (!(req_valid && req_stall)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (sample_q.size() > 0 && !reset) begin
            w = sample_q.pop_front();
            req_sample  <= w.sample;
            req_is_last <= w.is_last;
            req_valid   <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor and stall bursts
   int rsp_gap = 0;
   always @(posedge clock) begin
      smooth_word_type e;
      if (rsp_valid && !rsp_stall) begin
         if (smoothed_q.size() == 0)
            report_mismatch($sformatf("unexpected word %0d", rsp_smoothed));
         else begin
            e = smoothed_q.pop_front();
            if (rsp_smoothed !== e.smoothed)
               report_mismatch($sformatf("smoothed %0d, want %0d", rsp_smoothed, e.smoothed));
            if (rsp_is_last_res !== e.is_last_res)
               report_mismatch($sformatf("is_last_res %0b, want %0b",
                                         rsp_is_last_res, e.is_last_res));
         end
      end
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!quiet && $urandom_range(0, 4) == 0) rsp_gap = $urandom_range(1, 12);
      end
   end

   // hang detection
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return S_MAX;
         1: return S_MIN;
         2: return 32'sd0;
         3: return -32'sd1;
         4: return $signed(32'($urandom_range(0, 40))) - 20;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic add_word(input logic signed [31:0] s, input logic last);
      sample_q.push_back('{s, last});
   endtask

   // random sequences; mostly well-formed, sometimes left open
   task automatic add_sequences(input int words);
      int n;
      while (words > 0) begin
         n = $urandom_range(1, 14);
         for (int i = 0; i < n && words > 0; i++) begin
            words--;
            add_word(pick_sample(), (i == n - 1) || (words == 0 && $urandom_range(0, 1)));
         end
      end
   endtask

   task automatic wait_drained();
      while (sample_q.size() > 0 || req_valid || smoothed_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_order(input logic [OB-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      set_order(v);
      csr_valid <= 1'b0;
   endtask

   initial begin
      set_order(bsf_pkg::ORDER_RESET);
      foreach (win[i]) win[i] = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset order: lone last word, extremes, short sequence
      add_word(S_MAX, 1'b1);
      add_word(S_MIN, 1'b1);
      add_word(S_MAX, 1'b0);
      add_word(S_MAX, 1'b0);
      add_word(S_MIN, 1'b0);
      add_word(32'sd0, 1'b0);
      add_word(-32'sd1, 1'b0);
      add_word(32'sd7, 1'b1);
      add_word(32'sd5, 1'b0);
      wait_drained();  // leaves a sequence open across the write

      // pass-through order, then saturating and widest orders
      write_order(5'd0);
      add_word(S_MIN, 1'b0);
      add_word(S_MAX, 1'b0);
      add_word(-32'sd3, 1'b1);
      wait_drained();
      write_order(5'd31);
      for (int i = 0; i < 10; i++) add_word((i % 2) ? S_MAX : S_MIN, i == 9);
      wait_drained();
      write_order(5'd16);
      add_word(S_MAX, 1'b1);
      for (int i = 0; i < 4; i++) add_word(S_MIN, i == 3);
      wait_drained();

      // random part across several orders
      begin
         int orders[8] = '{1, 3, 16, 0, 7, 2, 20, 4};
         for (int k = 0; k < 8; k++) begin
            write_order(orders[k][OB-1:0]);
            if (k == 7) quiet = 1'b1;
            add_sequences(22);
            wait_drained();
         end
      end

      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

[binomial_smoothing_filter.f]
design/bsf_pkg.sv
design/bsf_cell.sv
design/bsf_divider.sv
design/binomial_smoothing_filter.sv
bench/tb_binomial_smoothing_filter.sv
